FILE: sv/xsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xsg_pkg;

  // Generator constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] STAR_MUL     = 64'h2545_F491_4F6C_DD1D;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned FRAC_SHIFT  = WORD_W - FRAC_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] seed;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // xorshift advance: 12 right, 25 left, 27 right
  function automatic logic [63:0] advance(input logic [63:0] x);
    logic [63:0] t;
    t = x ^ (x >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/xsg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module xsg_queue #(
  parameter int unsigned Depth = xsg_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  xsg_pkg::cmd_t     cmd_i,
  input  wire               pop_i,
  output xsg_pkg::cmd_t     cmd_o,
  output xsg_pkg::q_status_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  xsg_pkg::cmd_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: sv/xsg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module xsg_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                mode_i,
  input  wire  [63:0]        seed_i,
  input  xsg_pkg::q_status_t q_stat_i,
  output logic               push_o,
  output xsg_pkg::cmd_t      cmd_o
);

  logic          hold_q, hold_d;
  xsg_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;

  // holding register drains into the queue whenever there is room
  assign push_o     = hold_q && !q_stat_i.full;
  assign in_stall_o = hold_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hold_d = hold_q;
    cmd_d  = cmd_q;
    if (accept) begin
      hold_d     = 1'b1;
      cmd_d.op   = mode_i ? xsg_pkg::OP_DRAW : xsg_pkg::OP_SEED;
      cmd_d.seed = seed_i;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_o = cmd_q;

endmodule

`default_nettype wire

FILE: sv/xsg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module xsg_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  xsg_pkg::q_status_t q_stat_i,
  input  xsg_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [63:0]        random_word_o,
  output logic [23:0]        uniform_fraction_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    PH_DRAW  = 3'b001,
    PH_MIX_A = 3'b010,
    PH_MIX_B = 3'b100
  } phase_e;

  state_e      st_q, st_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] gen_q, gen_d;
  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] word_q, word_d;

  logic [63:0] b_full;
  logic [31:0] a_half, b_half;
  logic [63:0] mul_sum;
  logic [63:0] adv;
  logic [63:0] seed_pre;
  logic [63:0] mix_fin;

  always_comb begin
    unique case (phase_q)
      PH_DRAW:  b_full = xsg_pkg::STAR_MUL;
      PH_MIX_A: b_full = xsg_pkg::MIX_MUL_A;
      PH_MIX_B: b_full = xsg_pkg::MIX_MUL_B;
      default:  b_full = xsg_pkg::STAR_MUL;
    endcase
  end

  // low 64 bits of a*b: lo*lo, then the two cross terms shifted up 32
  assign a_half   = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
  assign b_half   = (step_q == 2'd2) ? b_full[63:32] : b_full[31:0];
  assign prod_d   = a_half * b_half;
  assign mul_sum  = acc_q + {prod_q[31:0], 32'h0};

  assign adv      = xsg_pkg::advance(gen_q);
  assign seed_pre = (cmd_i.seed + xsg_pkg::GOLDEN_GAMMA)
                  ^ ((cmd_i.seed + xsg_pkg::GOLDEN_GAMMA) >> 30);
  assign mix_fin  = mul_sum ^ (mul_sum >> 31);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    step_d      = step_q;
    gen_d       = gen_q;
    a_d         = a_q;
    acc_d       = acc_q;
    word_d      = word_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (st_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          step_d = 2'd0;
          st_d   = ST_MUL;
          if (cmd_i.op == xsg_pkg::OP_DRAW) begin
            gen_d   = adv;
            a_d     = adv;
            phase_d = PH_DRAW;
          end else begin
            a_d     = seed_pre;
            phase_d = PH_MIX_A;
          end
        end
      end
      ST_MUL: begin
        step_d = step_q + 2'd1;
        unique case (step_q)
          2'd0: ;
          2'd1: acc_d = prod_q;
          2'd2: acc_d = mul_sum;
          2'd3: begin
            unique case (phase_q)
              PH_DRAW: begin
                acc_d = mul_sum;
                st_d  = ST_OUT;
              end
              PH_MIX_A: begin
                a_d     = mul_sum ^ (mul_sum >> 27);
                phase_d = PH_MIX_B;
              end
              PH_MIX_B: begin
                gen_d = (mix_fin == '0) ? xsg_pkg::GOLDEN_GAMMA : mix_fin;
                st_d  = ST_IDLE;
              end
              default: st_d = ST_IDLE;
            endcase
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          word_d      = acc_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      gen_q       <= xsg_pkg::GOLDEN_GAMMA;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      gen_q       <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    step_q  <= step_d;
    a_q     <= a_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    word_q  <= word_d;
  end

  assign out_valid_o        = out_valid_q;
  assign random_word_o      = word_q;
  assign uniform_fraction_o = word_q[63:xsg_pkg::FRAC_SHIFT];

endmodule

`default_nettype wire

FILE: sv/xorshift64_star_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A draw yields a result word; a seed only reloads the state. Both run one at a time,
// serialised by the shared 32x32 multiplier (three partial products plus accumulate
//   per 64-bit multiply, two multiplies per seed).
// Input is taken while the back end works, up to QueueDepth + 1 items ahead.
// Reset (async, active low): queue empty, no result pending, state = 0x9E3779B97F4A7C15.

module xorshift64_star_generator_core #(
  parameter int unsigned QueueDepth = xsg_pkg::QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command transactions
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         mode_i,
  input  wire  [63:0] seed_i,
  // result transactions
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] random_word_o,
  output logic [23:0] uniform_fraction_o
);

  xsg_pkg::cmd_t      push_cmd;
  xsg_pkg::cmd_t      pop_cmd;
  xsg_pkg::q_status_t q_stat;
  logic               push;
  logic               pop;

  // Front: register the transaction and decode mode into an opcode.
  xsg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .seed_i     (seed_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Short command queue decoupling intake from execution.
  xsg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (q_stat)
  );

  // Back: state update, seed mixing and output scramble on one multiplier.
  xsg_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_stat_i           (q_stat),
    .cmd_i              (pop_cmd),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .random_word_o      (random_word_o),
    .uniform_fraction_o (uniform_fraction_o)
  );

  // Queue status is never full and empty at once.
  a_q_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Back end only pops a present command.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Front end only pushes into a queue with room.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire
